// ===== design/apid_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apid_pkg
// Shared constants and helpers for the pair index decoder.
// ---------------------------------------------------------------------------
package apid_pkg;

  localparam int IDX_W          = 40;
  localparam int COUNT_BITS_DEF = 20;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SELF_PAIRING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_COUNT = 2'd2;

  // accumulator width: holds the index and any shifted step term
  function automatic int acc_width(input int cb);
    int w;
    begin
      w = (IDX_W > 2 * cb) ? IDX_W : 2 * cb;
      return w + 1;
    end
  endfunction

endpackage

// ===== design/apid_range.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apid_range
// Input register and range check against the registered pair total.
// ---------------------------------------------------------------------------
module apid_range #(
  parameter int CB = apid_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [apid_pkg::IDX_W-1:0] idx_i,
  input  logic [2*CB:0]             total_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [apid_pkg::IDX_W-1:0] idx_o,
  output logic                      err_o
);
  localparam int W = apid_pkg::acc_width(CB);

  logic                       v0_q, v1_q;
  logic [apid_pkg::IDX_W-1:0] idx0_q, idx1_q;
  logic                       err_q, err_d;
  logic                       rdy1, rdy0;

  assign rdy1    = !v1_q || ready_i;
  assign rdy0    = !v0_q || rdy1;
  assign ready_o = rdy0;
  assign err_d   = W'(idx0_q) >= W'(total_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= valid_i;
      if (rdy1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) idx0_q <= idx_i;
    if (rdy1) begin
      idx1_q <= idx0_q;
      err_q  <= err_d;
    end
  end

  assign valid_o = v1_q;
  assign idx_o   = idx1_q;
  assign err_o   = err_q;
endmodule

// ===== design/apid_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apid_step
// One row bit of the search: try setting bit K and keep it if the offset
// of the candidate row still fits under the index.
// ---------------------------------------------------------------------------
module apid_step #(
  parameter int CB = apid_pkg::COUNT_BITS_DEF,
  parameter int K  = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       self_i,
  input  logic [CB-1:0]              div_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [apid_pkg::IDX_W-1:0] idx_i,
  input  logic [apid_pkg::acc_width(CB)-1:0] acc_i,
  input  logic [CB-1:0]              row_i,
  input  logic                       err_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [apid_pkg::IDX_W-1:0] idx_o,
  output logic [apid_pkg::acc_width(CB)-1:0] acc_o,
  output logic [CB-1:0]              row_o,
  output logic                       err_o
);
  localparam int W = apid_pkg::acc_width(CB);
  localparam longint unsigned BK = longint'(1) << K;
  // triangular step term 2^K (2^K + 1) / 2
  localparam logic [W-1:0] ADDK = W'((BK * (BK + 1)) >> 1);

  logic                       v_q;
  logic [apid_pkg::IDX_W-1:0] idx_q;
  logic [W-1:0]               acc_q, acc_d, cand;
  logic [CB-1:0]              row_q, row_d, base;
  logic                       err_q, take;

  assign ready_o = !v_q || ready_i;

  always_comb begin
    base  = self_i ? row_i : div_i;
    cand  = acc_i + (W'(base) << K) + (self_i ? ADDK : '0);
    take  = cand <= W'(idx_i);
    acc_d = take ? cand : acc_i;
    row_d = take ? (row_i | (CB'(1) << K)) : row_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      idx_q <= idx_i;
      acc_q <= acc_d;
      row_q <= row_d;
      err_q <= err_i;
    end
  end

  assign valid_o = v_q;
  assign idx_o   = idx_q;
  assign acc_o   = acc_q;
  assign row_o   = row_q;
  assign err_o   = err_q;
endmodule

// ===== design/all_pair_index_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// all_pair_index_decode
// Flat pair index to (row, column) element pair for an all-pairs search.
// ---------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled and returns one
// result per request, in order.
// The pipeline holds the input register and the range check, then one stage
// per row bit, each a shift-add and a compare, then the output register.
// In self-pairing mode the row is the largest r
// with r(r+1)/2 <= index and the column the remainder; in cross mode they are
// the quotient and remainder of the index by second_count. Indexes at or past
// the pair total give row = column = 0 with out_of_range set. The total is
// registered from the configuration registers, so it updates only after they do.
module all_pair_index_decode #(
  parameter int COUNT_BITS = apid_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [apid_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [COUNT_BITS-1:0]                  cfg_data_i,
  // request: tdata = pair_index
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [apid_pkg::IDX_W-1:0]             s_axis_tdata,
  // result: tdata = row_element, column_element, zero fill
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((2*COUNT_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // result: tuser = out_of_range
  output logic                                   m_axis_tuser
);
  localparam int CB  = COUNT_BITS;
  localparam int W   = apid_pkg::acc_width(CB);
  localparam int OW  = ((2*CB+7)/8)*8;

  // configuration registers
  logic          self_q;
  logic [CB-1:0] first_q, second_q;
  logic [2*CB:0] total_q, mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q   <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apid_pkg::REG_SELF_PAIRING: self_q   <= cfg_data_i[0];
        apid_pkg::REG_FIRST_COUNT:  first_q  <= cfg_data_i;
        apid_pkg::REG_SECOND_COUNT: second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pair total: n(n+1)/2 or n*m, one multiplier
  assign mul_b = self_q ? ((2*CB+1)'(first_q) + 1'b1) : (2*CB+1)'(second_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= self_q ? (((2*CB+1)'(first_q) * mul_b) >> 1)
                        : ((2*CB+1)'(first_q) * mul_b);
    end
  end

  // pipeline links: link 0 is the range stage output
  logic                       v_s   [0:CB];
  logic                       rdy_s [0:CB];
  logic [apid_pkg::IDX_W-1:0] idx_s [0:CB];
  logic [W-1:0]               acc_s [0:CB];
  logic [CB-1:0]              row_s [0:CB];
  logic                       err_s [0:CB];

  apid_range #(.CB(CB)) u_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .idx_i   (s_axis_tdata),
    .total_i (total_q),
    .valid_o (v_s[0]),
    .ready_i (rdy_s[0]),
    .idx_o   (idx_s[0]),
    .err_o   (err_s[0])
  );

  assign acc_s[0] = '0;
  assign row_s[0] = '0;

  // row search, most significant bit first
  for (genvar j = 0; j < CB; j++) begin : g_step
    apid_step #(.CB(CB), .K(CB-1-j)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .self_i  (self_q),
      .div_i   (second_q),
      .valid_i (v_s[j]),
      .ready_o (rdy_s[j]),
      .idx_i   (idx_s[j]),
      .acc_i   (acc_s[j]),
      .row_i   (row_s[j]),
      .err_i   (err_s[j]),
      .valid_o (v_s[j+1]),
      .ready_i (rdy_s[j+1]),
      .idx_o   (idx_s[j+1]),
      .acc_o   (acc_s[j+1]),
      .row_o   (row_s[j+1]),
      .err_o   (err_s[j+1])
    );
  end

  // output register: column is what is left of the index
  logic          out_v_q, out_err_q;
  logic [CB-1:0] out_row_q, out_col_q, col_d;
  logic [W-1:0]  rem;

  assign rdy_s[CB] = !out_v_q || m_axis_tready;
  assign rem       = W'(idx_s[CB]) - acc_s[CB];
  assign col_d     = rem[CB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_s[CB]) begin
      out_v_q <= v_s[CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_s[CB]) begin
      out_err_q <= err_s[CB];
      out_row_q <= err_s[CB] ? '0 : row_s[CB];
      out_col_q <= err_s[CB] ? '0 : col_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OW'({out_col_q, out_row_q});
  assign m_axis_tuser  = out_err_q;

`ifndef SYNTHESIS
  // an out-of-range result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> out_row_q == '0 && out_col_q == '0)
    else $error("out-of-range result with non-zero fields");

  // triangular pairs never sit above the diagonal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && self_q |-> out_col_q <= out_row_q)
    else $error("column above diagonal in self-pairing mode");

  // input back-pressure only comes from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request stalled with output free");
`endif
endmodule
